FILE: rtl/rrfs_pkg.sv
// Shared types, codes and helpers of the round-robin feedback scheduler.
`default_nettype none
package rrfs_pkg;

	localparam int PROCESSES_DEF = 8;
	localparam int MAX_IO = 4;
	localparam int IOW = (MAX_IO > 1) ? $clog2(MAX_IO) : 1;
	localparam int NQ = 6;

	localparam logic [1:0] CMD_DEFINE = 2'd0;
	localparam logic [1:0] CMD_IOREQ = 2'd1;
	localparam logic [1:0] CMD_TICK = 2'd2;
	localparam logic [1:0] CMD_NOP = 2'd3;

	localparam logic [1:0] EV_NONE = 2'd0;
	localparam logic [1:0] EV_IO = 2'd1;
	localparam logic [1:0] EV_FINISH = 2'd2;
	localparam logic [1:0] EV_QUANTUM = 2'd3;

	localparam logic [1:0] DEV_DISK = 2'd0;
	localparam logic [1:0] DEV_TAPE = 2'd1;

	localparam logic [2:0] Q_NEW = 3'd0;
	localparam logic [2:0] Q_HIGH = 3'd1;
	localparam logic [2:0] Q_LOW = 3'd2;
	localparam logic [2:0] Q_DISK = 3'd3;
	localparam logic [2:0] Q_TAPE = 3'd4;
	localparam logic [2:0] Q_PRN = 3'd5;

	localparam logic [2:0] REG_QUANTUM = 3'd0;
	localparam logic [2:0] REG_DISK = 3'd1;
	localparam logic [2:0] REG_TAPE = 3'd2;
	localparam logic [2:0] REG_PRINTER = 3'd3;
	localparam logic [2:0] REG_PCOUNT = 3'd4;

	typedef struct packed {
		logic [1:0]  command;
		logic [2:0]  pid;
		logic [15:0] arrival_time;
		logic [15:0] service_time;
		logic [2:0]  io_count;
		logic [1:0]  io_index;
		logic [15:0] io_point;
		logic [1:0]  io_device;
	} cmd_t;

	typedef struct packed {
		logic [15:0] tick_time;
		logic [1:0]  event_res;
		logic [2:0]  left_pid;
		logic [7:0]  slice_length;
		logic [15:0] turnaround;
		logic        cpu_busy;
		logic [2:0]  running_pid;
		logic        from_high;
		logic        idle_ended;
		logic [15:0] idle_length;
		logic        all_done;
	} res_t;

	typedef struct packed {
		logic [7:0] quantum;
		logic [7:0] disk_time;
		logic [7:0] tape_time;
		logic [7:0] printer_time;
		logic [3:0] process_count;
	} cfg_t;

	typedef struct packed {
		logic [15:0]                    arrival;
		logic [15:0]                    service;
		logic [15:0]                    remaining;
		logic [2:0]                     io_total;
		logic [2:0]                     io_next;
		logic [7:0]                     io_left;
		logic [MAX_IO-1:0][15:0]        io_point;
		logic [MAX_IO-1:0][1:0]         io_device;
	} proc_t;

	typedef struct packed {
		logic       rd_en;
		logic [2:0] rd_pid;
		logic       wr_en;
		logic [2:0] wr_pid;
		proc_t      wr_data;
	} pmem_req_t;

	typedef struct packed {
		logic       rd_en;
		logic [2:0] rd_q;
		logic       push_en;
		logic [2:0] push_q;
		logic [2:0] push_pid;
		logic       pop_en;
		logic [2:0] pop_q;
	} qreq_t;

	// io_next modulo MAX_IO by repeated subtraction
	function automatic logic [IOW-1:0] io_slot(input logic [2:0] n);
		logic [4:0] r;
		r = {2'b00, n};
		for (int i = 0; i < 8; i++) begin
			if (r >= 5'(MAX_IO)) begin
				r = r - 5'(MAX_IO);
			end
		end
		return IOW'(r);
	endfunction

endpackage
`default_nettype wire

FILE: rtl/rrfs_proc_mem.sv
// Per-process table memory, one write and one registered read per cycle.
`default_nettype none
module rrfs_proc_mem #(
	parameter int PROCESSES = rrfs_pkg::PROCESSES_DEF
) (
	input  wire                clk,
	input  rrfs_pkg::pmem_req_t req,
	output rrfs_pkg::proc_t    rd_data
);
	localparam int PW = (PROCESSES > 1) ? $clog2(PROCESSES) : 1;

	rrfs_pkg::proc_t mem [PROCESSES];
	rrfs_pkg::proc_t rd_q;

	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem[PW'(req.wr_pid)] <= req.wr_data;
		end
		if (req.rd_en) begin
			rd_q <= mem[PW'(req.rd_pid)];
		end
	end

	assign rd_data = rd_q;
endmodule
`default_nettype wire

FILE: rtl/rrfs_queue.sv
// Six process FIFOs sharing one entry memory, with head/tail/count registers.
`default_nettype none
module rrfs_queue #(
	parameter int PROCESSES = rrfs_pkg::PROCESSES_DEF,
	parameter int CW = $clog2(PROCESSES + 1)
) (
	input  wire                               clk,
	input  wire                               arst_n,
	input  rrfs_pkg::qreq_t                    req,
	output logic [2:0]                         rd_pid,
	output logic [rrfs_pkg::NQ-1:0][CW-1:0]    counts
);
	localparam int PW = (PROCESSES > 1) ? $clog2(PROCESSES) : 1;
	localparam int QAW = (rrfs_pkg::NQ * PROCESSES > 1) ? $clog2(rrfs_pkg::NQ * PROCESSES) : 1;

	logic [2:0] mem [rrfs_pkg::NQ * PROCESSES];
	logic [rrfs_pkg::NQ-1:0][PW-1:0] head_q, tail_q;
	logic [rrfs_pkg::NQ-1:0][CW-1:0] cnt_q;
	logic [rrfs_pkg::NQ-1:0] pop_ok, push_ok;
	logic [2:0] rd_q;
	logic [QAW-1:0] wr_addr, rd_addr;

	always_comb begin
		for (int q = 0; q < rrfs_pkg::NQ; q++) begin
			pop_ok[q] = req.pop_en && (req.pop_q == 3'(q)) && (cnt_q[q] != '0);
			push_ok[q] = req.push_en && (req.push_q == 3'(q)) &&
				((cnt_q[q] - CW'(pop_ok[q])) < CW'(PROCESSES));
		end
	end

	assign wr_addr = QAW'(req.push_q) * QAW'(PROCESSES) + QAW'(tail_q[req.push_q]);
	assign rd_addr = QAW'(req.rd_q) * QAW'(PROCESSES) + QAW'(head_q[req.rd_q]);

	always_ff @(posedge clk) begin
		if (push_ok[req.push_q]) begin
			mem[wr_addr] <= req.push_pid;
		end
		if (req.rd_en) begin
			rd_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			tail_q <= '0;
			cnt_q <= '0;
		end else begin
			for (int q = 0; q < rrfs_pkg::NQ; q++) begin
				if (pop_ok[q]) begin
					head_q[q] <= (head_q[q] == PW'(PROCESSES - 1)) ? '0 : head_q[q] + 1'b1;
				end
				if (push_ok[q]) begin
					tail_q[q] <= (tail_q[q] == PW'(PROCESSES - 1)) ? '0 : tail_q[q] + 1'b1;
				end
				cnt_q[q] <= cnt_q[q] - CW'(pop_ok[q]) + CW'(push_ok[q]);
			end
		end
	end

	assign rd_pid = rd_q;
	assign counts = cnt_q;
endmodule
`default_nettype wire

FILE: rtl/rrfs_seq.sv
// Tick sequencer: walks arrivals, CPU decision, devices and service per command.
`default_nettype none
module rrfs_seq #(
	parameter int PROCESSES = rrfs_pkg::PROCESSES_DEF,
	parameter int CW = $clog2(PROCESSES + 1)
) (
	input  wire                             clk,
	input  wire                             arst_n,
	input  wire                             cmd_valid,
	output logic                            cmd_stall,
	input  rrfs_pkg::cmd_t                  cmd,
	output logic                            res_valid,
	input  wire                             res_stall,
	output rrfs_pkg::res_t                  res,
	input  rrfs_pkg::cfg_t                  cfg,
	output rrfs_pkg::pmem_req_t             pm_req,
	input  rrfs_pkg::proc_t                 pm_rd,
	output rrfs_pkg::qreq_t                 q_req,
	input  wire [2:0]                       q_rd_pid,
	input  wire [rrfs_pkg::NQ-1:0][CW-1:0]  counts
);
	typedef enum logic [3:0] {
		ST_IDLE, ST_DEF_WR, ST_IO_WR, ST_ARR_RD, ST_ARR_PID, ST_ARR_CHK, ST_PICK,
		ST_PICK_W, ST_CPU_RD, ST_CPU_EV, ST_DEV_RD, ST_DEV_PID, ST_DEV_WR, ST_FIN,
		ST_REM_WR, ST_OUT
	} state_t;

	state_t state_q;
	rrfs_pkg::cmd_t c_q;
	rrfs_pkg::res_t res_q;
	logic res_valid_q;
	logic [15:0] tick_q, idle_start_q, turn_q, ilen_q;
	logic [7:0] slice_q, slen_q;
	logic cpu_valid_q, high_q, idle_flag_q, ended_q, done_q;
	logic [2:0] cpu_pid_q, left_q, p_q;
	logic [3:0] fin_q;
	logic [1:0] ev_q, d_q;

	logic accept, pid_ok, idx_ok, io_hit, quantum_hit, have_high, have_low, out_free;
	logic [15:0] served;
	logic [rrfs_pkg::IOW-1:0] slot;
	logic [1:0] dev;
	logic [2:0] src, dq, dev_cur, dest;
	logic [7:0] dtime;
	rrfs_pkg::proc_t e;

	assign e = pm_rd;
	assign accept = cmd_valid && !cmd_stall;
	assign cmd_stall = (state_q != ST_IDLE);
	assign pid_ok = 32'(c_q.pid) < PROCESSES;
	assign idx_ok = 32'(c_q.io_index) < rrfs_pkg::MAX_IO;
	assign served = e.service - e.remaining;
	assign slot = rrfs_pkg::io_slot(e.io_next);
	assign io_hit = (e.io_next < e.io_total) && (e.io_point[slot] == served);
	assign dev = e.io_device[slot];
	assign src = high_q ? rrfs_pkg::Q_HIGH : rrfs_pkg::Q_LOW;
	assign quantum_hit = (cfg.quantum != 8'd0) && (slice_q == cfg.quantum);
	assign have_high = counts[rrfs_pkg::Q_HIGH] != '0;
	assign have_low = counts[rrfs_pkg::Q_LOW] != '0;
	assign dev_cur = rrfs_pkg::Q_DISK + {1'b0, d_q};
	assign dest = (d_q == 2'd0) ? rrfs_pkg::Q_LOW : rrfs_pkg::Q_HIGH;
	assign out_free = !res_valid_q || !res_stall;

	always_comb begin
		case (dev)
			rrfs_pkg::DEV_DISK: begin
				dq = rrfs_pkg::Q_DISK;
				dtime = cfg.disk_time;
			end
			rrfs_pkg::DEV_TAPE: begin
				dq = rrfs_pkg::Q_TAPE;
				dtime = cfg.tape_time;
			end
			default: begin
				dq = rrfs_pkg::Q_PRN;
				dtime = cfg.printer_time;
			end
		endcase
	end

	always_comb begin
		pm_req = '0;
		q_req = '0;
		case (state_q)
			ST_IDLE: begin
				if (accept && (32'(cmd.pid) < PROCESSES) &&
					((cmd.command == rrfs_pkg::CMD_DEFINE) ||
					((cmd.command == rrfs_pkg::CMD_IOREQ) &&
					(32'(cmd.io_index) < rrfs_pkg::MAX_IO)))) begin
					pm_req.rd_en = 1'b1;
					pm_req.rd_pid = cmd.pid;
				end
			end
			ST_DEF_WR: begin
				pm_req.wr_en = 1'b1;
				pm_req.wr_pid = c_q.pid;
				pm_req.wr_data = e;
				pm_req.wr_data.arrival = c_q.arrival_time;
				pm_req.wr_data.service = c_q.service_time;
				pm_req.wr_data.remaining = c_q.service_time;
				pm_req.wr_data.io_total = (32'(c_q.io_count) > rrfs_pkg::MAX_IO) ?
					3'(rrfs_pkg::MAX_IO) : c_q.io_count;
				pm_req.wr_data.io_next = 3'd0;
				pm_req.wr_data.io_left = 8'd0;
				q_req.push_en = 1'b1;
				q_req.push_q = rrfs_pkg::Q_NEW;
				q_req.push_pid = c_q.pid;
			end
			ST_IO_WR: begin
				pm_req.wr_en = 1'b1;
				pm_req.wr_pid = c_q.pid;
				pm_req.wr_data = e;
				pm_req.wr_data.io_point[rrfs_pkg::IOW'(c_q.io_index)] = c_q.io_point;
				pm_req.wr_data.io_device[rrfs_pkg::IOW'(c_q.io_index)] = c_q.io_device;
			end
			ST_ARR_RD: begin
				q_req.rd_en = counts[rrfs_pkg::Q_NEW] != '0;
				q_req.rd_q = rrfs_pkg::Q_NEW;
			end
			ST_ARR_PID, ST_DEV_PID: begin
				pm_req.rd_en = 1'b1;
				pm_req.rd_pid = q_rd_pid;
			end
			ST_ARR_CHK: begin
				if (e.arrival <= tick_q) begin
					q_req.pop_en = 1'b1;
					q_req.pop_q = rrfs_pkg::Q_NEW;
					q_req.push_en = 1'b1;
					q_req.push_q = rrfs_pkg::Q_HIGH;
					q_req.push_pid = p_q;
				end
			end
			ST_PICK: begin
				if (slice_q == 8'd0) begin
					q_req.rd_en = have_high || have_low;
					q_req.rd_q = have_high ? rrfs_pkg::Q_HIGH : rrfs_pkg::Q_LOW;
				end
			end
			ST_CPU_RD, ST_FIN: begin
				pm_req.rd_en = cpu_valid_q;
				pm_req.rd_pid = cpu_pid_q;
			end
			ST_CPU_EV: begin
				q_req.pop_q = src;
				if (io_hit) begin
					q_req.pop_en = 1'b1;
					pm_req.wr_en = 1'b1;
					pm_req.wr_pid = cpu_pid_q;
					pm_req.wr_data = e;
					pm_req.wr_data.io_left = dtime;
					q_req.push_en = 1'b1;
					q_req.push_q = dq;
					q_req.push_pid = cpu_pid_q;
				end else if (e.remaining == 16'd0) begin
					q_req.pop_en = 1'b1;
				end else if (quantum_hit) begin
					q_req.pop_en = 1'b1;
					q_req.push_en = 1'b1;
					q_req.push_q = rrfs_pkg::Q_LOW;
					q_req.push_pid = cpu_pid_q;
				end
			end
			ST_DEV_RD: begin
				q_req.rd_en = counts[dev_cur] != '0;
				q_req.rd_q = dev_cur;
			end
			ST_DEV_WR: begin
				pm_req.wr_en = 1'b1;
				pm_req.wr_pid = p_q;
				pm_req.wr_data = e;
				if (e.io_left <= 8'd1) begin
					pm_req.wr_data.io_left = 8'd0;
					if (e.io_next < 3'd7) begin
						pm_req.wr_data.io_next = e.io_next + 3'd1;
					end
					q_req.pop_en = 1'b1;
					q_req.pop_q = dev_cur;
					q_req.push_en = 1'b1;
					q_req.push_q = dest;
					q_req.push_pid = p_q;
				end else begin
					pm_req.wr_data.io_left = e.io_left - 8'd1;
				end
			end
			ST_REM_WR: begin
				pm_req.wr_en = e.remaining != 16'd0;
				pm_req.wr_pid = cpu_pid_q;
				pm_req.wr_data = e;
				pm_req.wr_data.remaining = e.remaining - 16'd1;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			res_valid_q <= 1'b0;
			tick_q <= '0;
			slice_q <= '0;
			cpu_valid_q <= 1'b0;
			cpu_pid_q <= '0;
			high_q <= 1'b0;
			fin_q <= '0;
			idle_flag_q <= 1'b0;
			idle_start_q <= '0;
			c_q <= '0;
			res_q <= '0;
			ev_q <= '0;
			left_q <= '0;
			slen_q <= '0;
			turn_q <= '0;
			ended_q <= 1'b0;
			ilen_q <= '0;
			done_q <= 1'b0;
			p_q <= '0;
			d_q <= '0;
		end else begin
			if (res_valid_q && !res_stall) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						c_q <= cmd;
						ev_q <= rrfs_pkg::EV_NONE;
						left_q <= '0;
						slen_q <= '0;
						turn_q <= '0;
						ended_q <= 1'b0;
						ilen_q <= '0;
						done_q <= 1'b0;
						d_q <= '0;
						if (cmd.command == rrfs_pkg::CMD_TICK) begin
							state_q <= ST_ARR_RD;
						end else if (32'(cmd.pid) >= PROCESSES) begin
							state_q <= ST_OUT;
						end else if (cmd.command == rrfs_pkg::CMD_DEFINE) begin
							state_q <= ST_DEF_WR;
						end else if ((cmd.command == rrfs_pkg::CMD_IOREQ) &&
							(32'(cmd.io_index) < rrfs_pkg::MAX_IO)) begin
							state_q <= ST_IO_WR;
						end else begin
							state_q <= ST_OUT;
						end
					end
				end
				ST_DEF_WR, ST_IO_WR: begin
					state_q <= (pid_ok && (idx_ok || c_q.command == rrfs_pkg::CMD_DEFINE)) ?
						ST_OUT : ST_OUT;
				end
				ST_ARR_RD: begin
					state_q <= (counts[rrfs_pkg::Q_NEW] != '0) ? ST_ARR_PID : ST_PICK;
				end
				ST_ARR_PID: begin
					p_q <= q_rd_pid;
					state_q <= ST_ARR_CHK;
				end
				ST_ARR_CHK: begin
					state_q <= (e.arrival <= tick_q) ? ST_ARR_RD : ST_PICK;
				end
				ST_PICK: begin
					if (slice_q == 8'd0) begin
						cpu_valid_q <= have_high || have_low;
						high_q <= have_high;
						if (have_high || have_low) begin
							state_q <= ST_PICK_W;
						end else begin
							cpu_pid_q <= '0;
							if (ev_q != rrfs_pkg::EV_NONE) begin
								done_q <= (counts[rrfs_pkg::Q_DISK] == '0) &&
									(counts[rrfs_pkg::Q_TAPE] == '0) &&
									(counts[rrfs_pkg::Q_PRN] == '0) &&
									(fin_q == cfg.process_count);
								state_q <= ST_DEV_RD;
							end else begin
								state_q <= ST_CPU_RD;
							end
						end
					end else begin
						state_q <= ST_CPU_RD;
					end
				end
				ST_PICK_W: begin
					cpu_pid_q <= q_rd_pid;
					state_q <= (ev_q != rrfs_pkg::EV_NONE) ? ST_DEV_RD : ST_CPU_RD;
				end
				ST_CPU_RD: begin
					if (cpu_valid_q) begin
						if (idle_flag_q) begin
							ended_q <= 1'b1;
							ilen_q <= tick_q - idle_start_q;
						end
						idle_flag_q <= 1'b0;
						state_q <= ST_CPU_EV;
					end else begin
						state_q <= ST_DEV_RD;
					end
				end
				ST_CPU_EV: begin
					if (io_hit || (e.remaining == 16'd0) || quantum_hit) begin
						left_q <= cpu_pid_q;
						slen_q <= slice_q;
						slice_q <= '0;
						state_q <= ST_PICK;
						if (io_hit) begin
							ev_q <= rrfs_pkg::EV_IO;
						end else if (e.remaining == 16'd0) begin
							ev_q <= rrfs_pkg::EV_FINISH;
							turn_q <= tick_q - e.arrival;
							if (fin_q < 4'd15) begin
								fin_q <= fin_q + 4'd1;
							end
						end else begin
							ev_q <= rrfs_pkg::EV_QUANTUM;
						end
					end else begin
						state_q <= ST_DEV_RD;
					end
				end
				ST_DEV_RD: begin
					if (counts[dev_cur] != '0) begin
						state_q <= ST_DEV_PID;
					end else if (d_q == 2'd2) begin
						state_q <= ST_FIN;
					end else begin
						d_q <= d_q + 2'd1;
					end
				end
				ST_DEV_PID: begin
					p_q <= q_rd_pid;
					state_q <= ST_DEV_WR;
				end
				ST_DEV_WR: begin
					if (d_q == 2'd2) begin
						state_q <= ST_FIN;
					end else begin
						d_q <= d_q + 2'd1;
						state_q <= ST_DEV_RD;
					end
				end
				ST_FIN: begin
					if (!cpu_valid_q) begin
						if (!idle_flag_q) begin
							idle_start_q <= tick_q;
						end
						idle_flag_q <= 1'b1;
						state_q <= ST_OUT;
					end else begin
						if (slice_q < 8'd255) begin
							slice_q <= slice_q + 8'd1;
						end
						state_q <= ST_REM_WR;
					end
				end
				ST_REM_WR: begin
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (out_free) begin
						res_valid_q <= 1'b1;
						res_q.tick_time <= tick_q;
						res_q.event_res <= ev_q;
						res_q.left_pid <= left_q;
						res_q.slice_length <= slen_q;
						res_q.turnaround <= turn_q;
						res_q.idle_ended <= ended_q;
						res_q.idle_length <= ilen_q;
						res_q.all_done <= done_q;
						if (c_q.command == rrfs_pkg::CMD_TICK) begin
							res_q.cpu_busy <= cpu_valid_q;
							res_q.running_pid <= cpu_valid_q ? cpu_pid_q : 3'd0;
							res_q.from_high <= cpu_valid_q && high_q;
							tick_q <= tick_q + 16'd1;
						end else begin
							res_q.cpu_busy <= 1'b0;
							res_q.running_pid <= '0;
							res_q.from_high <= 1'b0;
						end
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign res_valid = res_valid_q;
	assign res = res_q;
endmodule
`default_nettype wire

FILE: rtl/round_robin_feedback_scheduler.sv
// Top level of the round-robin feedback scheduler: config registers and wiring.
// Usage: load processes (command 0) and their I/O requests (command 1) first,
// then send one command 2 beat per scheduler tick. Every command beat on the
// cmd channel yields exactly one result beat on the res channel, in order.
// Both channels use valid/stall; a beat moves when valid is high and stall low.
// A define or I/O request command reads, then writes the process table;
// an ignored command goes straight to its result. A tick walks the arrival list
// (once per admitted process), the CPU decision (again when a process leaves
// the CPU), each busy device (at most three) and the service step; each is
// a read-modify-write of process table or queue memory; reads are registered.
// One command is in flight at a time; the next command is taken as soon as the
// previous result sits in the output register, even while that result stalls.
// A stalled result holds; the sequencer waits only when a newer result is ready.
// Write registers (wr_en/wr_index/wr_data) only while idle; the block does not
// enforce this. Reset clears the tick count, CPU and idle state and empties all
// six queues; the process table holds no valid data until it is loaded.
`default_nettype none
module round_robin_feedback_scheduler #(
	parameter int PROCESSES = rrfs_pkg::PROCESSES_DEF
) (
	input  wire             clk,
	input  wire             arst_n,
	input  wire             cmd_valid,
	output logic            cmd_stall,
	input  rrfs_pkg::cmd_t  cmd,
	output logic            res_valid,
	input  wire             res_stall,
	output rrfs_pkg::res_t  res,
	input  wire             wr_en,
	input  wire [2:0]       wr_index,
	input  wire [7:0]       wr_data
);
	localparam int CW = $clog2(PROCESSES + 1);

	rrfs_pkg::cfg_t cfg_q;
	rrfs_pkg::pmem_req_t pm_req;
	rrfs_pkg::proc_t pm_rd;
	rrfs_pkg::qreq_t q_req;
	logic [2:0] q_rd_pid;
	logic [rrfs_pkg::NQ-1:0][CW-1:0] counts;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.quantum <= 8'd3;
			cfg_q.disk_time <= 8'd4;
			cfg_q.tape_time <= 8'd8;
			cfg_q.printer_time <= 8'd12;
			cfg_q.process_count <= 4'd5;
		end else if (wr_en) begin
			case (wr_index)
				rrfs_pkg::REG_QUANTUM: cfg_q.quantum <= wr_data;
				rrfs_pkg::REG_DISK: cfg_q.disk_time <= wr_data;
				rrfs_pkg::REG_TAPE: cfg_q.tape_time <= wr_data;
				rrfs_pkg::REG_PRINTER: cfg_q.printer_time <= wr_data;
				rrfs_pkg::REG_PCOUNT: cfg_q.process_count <= wr_data[3:0];
				default: begin
				end
			endcase
		end
	end

	rrfs_proc_mem #(.PROCESSES(PROCESSES)) u_proc_mem (
		.clk     (clk),
		.req     (pm_req),
		.rd_data (pm_rd)
	);

	rrfs_queue #(.PROCESSES(PROCESSES), .CW(CW)) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (q_req),
		.rd_pid (q_rd_pid),
		.counts (counts)
	);

	rrfs_seq #(.PROCESSES(PROCESSES), .CW(CW)) u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.cmd       (cmd),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res       (res),
		.cfg       (cfg_q),
		.pm_req    (pm_req),
		.pm_rd     (pm_rd),
		.q_req     (q_req),
		.q_rd_pid  (q_rd_pid),
		.counts    (counts)
	);
endmodule
`default_nettype wire

FILE: tb/sv/testbench.sv
// Self-checking testbench for the round-robin feedback scheduler.
`default_nettype none

module testbench;

	localparam int STALL_LIMIT = 4000;
	localparam int SETTLE = 60;
	localparam int LONG_HOLD = 300;

	class sched_scoreboard;
		bit [7:0] quantum = 3, disk_time = 4, tape_time = 8, printer_time = 12;
		bit [3:0] proc_count = 5;
		bit [15:0] tick;
		bit [7:0] slice;
		bit busy, hsrc, idle;
		bit [2:0] cpu;
		bit [3:0] nfin;
		bit [15:0] idle_st;
		bit [15:0] arr[8], svc[8], rem[8];
		bit [2:0] io_tot[8], io_nxt[8];
		bit [7:0] io_left[8];
		bit [15:0] io_pt[32];
		bit [1:0] io_dev[32];
		bit [2:0] q_ent[6][8];
		bit [2:0] q_hd[6], q_tl[6];
		bit [3:0] q_cnt[6];
		rrfs_pkg::res_t pending[$];
		int errors;

		function void set_reg(logic [2:0] idx, bit [7:0] val);
			case (idx)
				rrfs_pkg::REG_QUANTUM: quantum = val;
				rrfs_pkg::REG_DISK: disk_time = val;
				rrfs_pkg::REG_TAPE: tape_time = val;
				rrfs_pkg::REG_PRINTER: printer_time = val;
				rrfs_pkg::REG_PCOUNT: proc_count = val[3:0];
				default: ;
			endcase
		endfunction

		function void enqueue(int q, bit [2:0] p);
			if (q_cnt[q] >= 8) return;
			q_ent[q][q_tl[q]] = p;
			q_tl[q]++;
			q_cnt[q]++;
		endfunction

		function void dequeue(int q);
			if (q_cnt[q] == 0) return;
			q_hd[q]++;
			q_cnt[q]--;
		endfunction

		function bit [2:0] head(int q);
			return q_ent[q][q_hd[q]];
		endfunction

		function void dispatch();
			if (q_cnt[rrfs_pkg::Q_HIGH] != 0) begin
				busy = 1; hsrc = 1; cpu = head(rrfs_pkg::Q_HIGH);
			end else if (q_cnt[rrfs_pkg::Q_LOW] != 0) begin
				busy = 1; hsrc = 0; cpu = head(rrfs_pkg::Q_LOW);
			end else begin
				busy = 0; hsrc = 0; cpu = 0;
			end
		endfunction

		function void serve_device(int q, int dest);
			bit [2:0] p;
			if (q_cnt[q] == 0) return;
			p = head(q);
			if (io_left[p] <= 1) begin
				io_left[p] = 0;
				if (io_nxt[p] < 7) io_nxt[p]++;
				dequeue(q);
				enqueue(dest, p);
			end else begin
				io_left[p]--;
			end
		endfunction

		function void note_cmd(rrfs_pkg::cmd_t c);
			rrfs_pkg::res_t r;
			bit [2:0] p;
			bit [15:0] served;
			bit [4:0] slot;
			bit hit;
			bit [1:0] dev;
			bit [2:0] cnt;
			int src;
			r = '0;
			r.tick_time = tick;
			if (c.command == rrfs_pkg::CMD_DEFINE) begin
				cnt = (c.io_count > rrfs_pkg::MAX_IO) ? 3'(rrfs_pkg::MAX_IO) : c.io_count;
				arr[c.pid] = c.arrival_time;
				svc[c.pid] = c.service_time;
				rem[c.pid] = c.service_time;
				io_tot[c.pid] = cnt;
				io_nxt[c.pid] = 0;
				io_left[c.pid] = 0;
				enqueue(rrfs_pkg::Q_NEW, c.pid);
			end else if (c.command == rrfs_pkg::CMD_IOREQ) begin
				io_pt[{c.pid, c.io_index}] = c.io_point;
				io_dev[{c.pid, c.io_index}] = c.io_device;
			end else if (c.command == rrfs_pkg::CMD_TICK) begin
				while (q_cnt[rrfs_pkg::Q_NEW] != 0 && arr[head(rrfs_pkg::Q_NEW)] <= tick) begin
					p = head(rrfs_pkg::Q_NEW);
					dequeue(rrfs_pkg::Q_NEW);
					enqueue(rrfs_pkg::Q_HIGH, p);
				end
				if (slice == 0) dispatch();
				if (busy) begin
					p = cpu;
					src = hsrc ? rrfs_pkg::Q_HIGH : rrfs_pkg::Q_LOW;
					served = svc[p] - rem[p];
					hit = 0;
					dev = rrfs_pkg::DEV_DISK;
					if (idle) begin
						r.idle_ended = 1;
						r.idle_length = tick - idle_st;
					end
					idle = 0;
					if (io_nxt[p] < io_tot[p]) begin
						slot = {p, io_nxt[p][1:0]};
						dev = io_dev[slot];
						hit = (io_pt[slot] == served);
					end
					if (hit) begin
						r.event_res = rrfs_pkg::EV_IO;
						dequeue(src);
						if (dev == rrfs_pkg::DEV_DISK) begin
							io_left[p] = disk_time;
							enqueue(rrfs_pkg::Q_DISK, p);
						end else if (dev == rrfs_pkg::DEV_TAPE) begin
							io_left[p] = tape_time;
							enqueue(rrfs_pkg::Q_TAPE, p);
						end else begin
							io_left[p] = printer_time;
							enqueue(rrfs_pkg::Q_PRN, p);
						end
					end else if (rem[p] == 0) begin
						r.event_res = rrfs_pkg::EV_FINISH;
						dequeue(src);
						r.turnaround = tick - arr[p];
						if (nfin < 15) nfin++;
					end else if (quantum != 0 && slice == quantum) begin
						r.event_res = rrfs_pkg::EV_QUANTUM;
						dequeue(src);
						enqueue(rrfs_pkg::Q_LOW, p);
					end
					if (r.event_res != rrfs_pkg::EV_NONE) begin
						r.left_pid = p;
						r.slice_length = slice;
						slice = 0;
						dispatch();
						r.all_done = !busy && q_cnt[rrfs_pkg::Q_DISK] == 0 &&
							q_cnt[rrfs_pkg::Q_TAPE] == 0 &&
							q_cnt[rrfs_pkg::Q_PRN] == 0 && nfin == proc_count;
					end
				end
				r.cpu_busy = busy;
				r.running_pid = busy ? cpu : 3'd0;
				r.from_high = busy ? hsrc : 1'b0;
				serve_device(rrfs_pkg::Q_DISK, rrfs_pkg::Q_LOW);
				serve_device(rrfs_pkg::Q_TAPE, rrfs_pkg::Q_HIGH);
				serve_device(rrfs_pkg::Q_PRN, rrfs_pkg::Q_HIGH);
				if (!busy) begin
					if (!idle) idle_st = tick;
					idle = 1;
				end else begin
					if (slice < 255) slice++;
					if (rem[cpu] > 0) rem[cpu]--;
				end
				tick++;
			end
			pending.push_back(r);
		endfunction

		function void cmp(string f, logic [15:0] e, logic [15:0] a);
			if (e !== a) begin
				$display("%0t %s mismatch: expected %0d actual %0d", $time, f, e, a);
				errors++;
			end
		endfunction

		function void check(rrfs_pkg::res_t a);
			rrfs_pkg::res_t e;
			if (pending.size() == 0) begin
				$display("%0t unexpected result: tick %0d", $time, a.tick_time);
				errors++;
				return;
			end
			e = pending.pop_front();
			cmp("tick_time", e.tick_time, a.tick_time);
			cmp("event_res", e.event_res, a.event_res);
			cmp("left_pid", e.left_pid, a.left_pid);
			cmp("slice_length", e.slice_length, a.slice_length);
			cmp("turnaround", e.turnaround, a.turnaround);
			cmp("cpu_busy", e.cpu_busy, a.cpu_busy);
			cmp("running_pid", e.running_pid, a.running_pid);
			cmp("from_high", e.from_high, a.from_high);
			cmp("idle_ended", e.idle_ended, a.idle_ended);
			cmp("idle_length", e.idle_length, a.idle_length);
			cmp("all_done", e.all_done, a.all_done);
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic cmd_valid;
	logic cmd_stall;
	rrfs_pkg::cmd_t cmd;
	logic res_valid;
	logic res_stall;
	rrfs_pkg::res_t res;
	logic wr_en;
	logic [2:0] wr_index;
	logic [7:0] wr_data;

	sched_scoreboard sb = new();
	bit tx_burst;
	bit rx_burst;
	bit hold_request;
	int quiet_cycles;

	round_robin_feedback_scheduler DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cmd_valid(cmd_valid),
		.cmd_stall(cmd_stall),
		.cmd(cmd),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.res(res),
		.wr_en(wr_en),
		.wr_index(wr_index),
		.wr_data(wr_data)
	);

	initial begin
		clk = 0;
		forever #6 clk = ~clk;
	end

	function automatic rrfs_pkg::cmd_t noise_cmd();
		rrfs_pkg::cmd_t c;
		c = rrfs_pkg::cmd_t'(60'({$urandom, $urandom}));
		return c;
	endfunction

	task automatic send(rrfs_pkg::cmd_t c);
		int gap;
		gap = tx_burst ? 0 : $urandom_range(0, 10);
		if (gap > 0) begin
			cmd_valid <= 0;
			repeat (gap) @(posedge clk);
		end
		cmd_valid <= 1;
		cmd <= c;
		do @(posedge clk); while (cmd_stall);
		sb.note_cmd(c);
	endtask

	task automatic send_define(bit [2:0] pid, bit [15:0] arrival, bit [15:0] service,
			bit [2:0] ioc);
		rrfs_pkg::cmd_t c;
		bit [15:0] pt;
		c = noise_cmd();
		c.command = rrfs_pkg::CMD_DEFINE;
		c.pid = pid;
		c.arrival_time = arrival;
		c.service_time = service;
		c.io_count = ioc;
		send(c);
		for (int i = 0; i < ((ioc > rrfs_pkg::MAX_IO) ? rrfs_pkg::MAX_IO : ioc); i++) begin
			c = noise_cmd();
			c.command = rrfs_pkg::CMD_IOREQ;
			c.pid = pid;
			c.io_index = i[1:0];
			pt = (service > 40) ? 16'($urandom_range(0, 40)) : 16'($urandom_range(0, service));
			c.io_point = ($urandom_range(0, 15) == 0) ? 16'hFFFF : pt;
			send(c);
		end
	endtask

	task automatic send_ticks(int n);
		rrfs_pkg::cmd_t c;
		for (int i = 0; i < n; i++) begin
			c = noise_cmd();
			c.command = ($urandom_range(0, 19) == 0) ? rrfs_pkg::CMD_NOP : rrfs_pkg::CMD_TICK;
			if ($urandom_range(0, 29) == 0) c.command = rrfs_pkg::CMD_IOREQ;
			if (c.command == rrfs_pkg::CMD_IOREQ) c.io_point = 16'hFFFF;
			send(c);
		end
	endtask

	task automatic program_regs(bit [7:0] q, bit [7:0] d, bit [7:0] t, bit [7:0] p,
			bit [3:0] pc);
		bit [7:0] vals[5];
		vals = '{q, d, t, p, {4'd0, pc}};
		cmd_valid <= 0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
		for (int i = 0; i < 5; i++) begin
			wr_en <= 1;
			wr_index <= 3'(i);
			wr_data <= vals[i];
			@(posedge clk);
			sb.set_reg(3'(i), vals[i]);
		end
		wr_en <= 0;
	endtask

	function automatic bit [7:0] pick_time();
		case ($urandom_range(0, 5))
			0: return 8'd0;
			1: return 8'd1;
			2: return 8'd255;
			default: return 8'($urandom_range(1, 10));
		endcase
	endfunction

	initial begin
		bit [7:0] qv;
		bit [3:0] pcv;
		int nproc;
		arst_n = 0;
		cmd_valid <= 0;
		cmd <= '0;
		res_stall <= 0;
		wr_en <= 0;
		wr_index <= '0;
		wr_data <= '0;
		repeat (12) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: late arrival, io clamp, zero service
		send_define(3'd0, 16'd0, 16'd3, 3'd1);
		send_define(3'd7, 16'd2, 16'd0, 3'd7);
		send_define(3'd3, 16'd0, 16'd5, 3'd0);
		send_define(3'd5, 16'd1, 16'd4, 3'd2);
		send_ticks(12);

		program_regs(8'd0, 8'd0, 8'd1, 8'd255, 4'd1);
		for (int s = 0; s < 15; s++) begin
			tx_burst = ($urandom_range(0, 3) == 0);
			if (s == 3) hold_request = 1;
			if (s > 0) begin
				case (s % 4)
					0: qv = 8'd255;
					1: qv = 8'd1;
					2: qv = 8'd0;
					default: qv = 8'($urandom_range(1, 8));
				endcase
				nproc = $urandom_range(3, 8);
				pcv = (sb.nfin + nproc <= 8) ? 4'(sb.nfin + nproc) : 4'($urandom_range(1, 8));
				if (s == 7) pcv = 4'd8;
				program_regs(qv, pick_time(), pick_time(), pick_time(), pcv);
			end else begin
				nproc = 4;
			end
			for (int i = 0; i < nproc; i++) begin
				send_define(3'($urandom_range(0, 7)), sb.tick + 16'($urandom_range(0, 15)),
					($urandom_range(0, 7) == 0) ? 16'($urandom_range(21, 60)) :
					16'($urandom_range(0, 20)),
					($urandom_range(0, 7) == 0) ? 3'($urandom_range(5, 7)) :
					3'($urandom_range(0, 4)));
			end
			send_ticks($urandom_range(60, 110));
		end

		// extremes of arrival and service
		tx_burst = 0;
		send_define(3'($urandom_range(0, 7)), 16'd0, 16'hFFFF, 3'd0);
		send_define(3'($urandom_range(0, 7)), 16'hFFFF, 16'd0, 3'd0);
		send_ticks(20);

		cmd_valid <= 0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
		if (sb.errors == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end

	initial begin
		int w;
		int beats;
		beats = 0;
		@(posedge arst_n);
		forever begin
			if ((beats & 15) == 0) rx_burst = ($urandom_range(0, 3) == 0);
			w = rx_burst ? 0 : $urandom_range(0, 10);
			if (hold_request) begin
				w = LONG_HOLD;
				hold_request = 0;
			end
			if (w > 0) begin
				res_stall <= 1;
				repeat (w) @(posedge clk);
				res_stall <= 0;
			end
			do @(posedge clk); while (!res_valid);
			sb.check(res);
			beats++;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((cmd_valid && !cmd_stall) || (res_valid && !res_stall)) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles >= STALL_LIMIT) begin
				$display("FAILED: results differ");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end else begin
			quiet_cycles <= 0;
		end
	end

endmodule

`default_nettype wire
